// File: hw/rtl/twmr_pkg.sv
package twmr_pkg;

  localparam int unsigned DepthDefault = 32;
  localparam logic [19:0] GroupReset = 20'd60;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_SUM   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StRange = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value_low;
    logic signed [31:0] value_high;
    logic [31:0]        timestamp;
    logic [4:0]         entry_age;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] result_low;
    logic signed [31:0] result_high;
    logic [32:0]        spread_least;
    logic [32:0]        spread_greatest;
    logic [31:0]        window_start;
    logic [5:0]         stored_windows;
  } out_item_t;

  // classified job handed from front to back
  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value_low;
    logic signed [31:0] value_high;
    logic [31:0]        tag;
    logic [4:0]         entry_age;
    logic [19:0]        period;
  } job_t;

endpackage

// File: hw/rtl/twmr_front.sv
// Front: accepts beats and computes the bucket tag with a radix-2 divider.
module twmr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  twmr_pkg::in_item_t in_data,
  input  logic [19:0]       period,
  output logic              job_valid,
  input  logic              job_stall,
  output twmr_pkg::job_t    job_data
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} st_t;

  st_t                st_r;
  twmr_pkg::in_item_t item_r;
  logic [19:0]        per_r;
  logic [31:0]        quo_r;
  logic [19:0]        rem_r;
  logic [4:0]         cnt_r;

  logic [20:0] trial;
  logic [20:0] diff;

  // one quotient bit per cycle
  always_comb begin
    trial = {rem_r, quo_r[31]};
    diff  = trial - {1'b0, per_r};
  end

  assign in_stall  = (st_r != S_IDLE);
  assign job_valid = (st_r == S_OUT);
  always_comb begin
    job_data.command    = item_r.command;
    job_data.value_low  = item_r.value_low;
    job_data.value_high = item_r.value_high;
    job_data.tag        = quo_r;
    job_data.entry_age  = item_r.entry_age;
    job_data.period     = per_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
            per_r  <= (period == 20'd0) ? 20'd1 : period;
            quo_r  <= in_data.timestamp;
            rem_r  <= '0;
            cnt_r  <= '0;
            st_r   <= (in_data.command == twmr_pkg::CMD_PUSH) ? S_DIV : S_OUT;
          end
        end
        S_DIV: begin
          if (!diff[20]) begin
            rem_r <= diff[19:0];
            quo_r <= {quo_r[30:0], 1'b1};
          end else begin
            rem_r <= trial[19:0];
            quo_r <= {quo_r[30:0], 1'b0};
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) st_r <= S_OUT;
        end
        S_OUT: begin
          if (!job_stall) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/twmr_queue.sv
// Two-entry queue between front and back.
module twmr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_stall,
  input  twmr_pkg::job_t wr_data,
  output logic           rd_valid,
  input  logic           rd_stall,
  output twmr_pkg::job_t rd_data
);

  twmr_pkg::job_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           push, pop;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: hw/rtl/twmr_back.sv
// Back: owns the window ring and executes jobs.
module twmr_back #(
  parameter int unsigned DEPTH = twmr_pkg::DepthDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_stall,
  input  twmr_pkg::job_t     job_data,
  output logic               out_valid,
  input  logic               out_stall,
  output twmr_pkg::out_item_t out_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_CMP, S_SCAN, S_MUL, S_OUT} st_t;

  st_t              st_r;
  twmr_pkg::job_t   job_r;
  logic [AW-1:0]    newest_r;
  logic [CW-1:0]    filled_r;
  logic [CW-1:0]    k_r;
  logic [AW-1:0]    ptr_r;

  logic signed [31:0] lo_mem [DEPTH];
  logic signed [31:0] hi_mem [DEPTH];
  logic [31:0]        tag_mem [DEPTH];
  logic signed [31:0] lo_q, hi_q;
  logic [31:0]        tag_q;

  logic               we;
  logic [AW-1:0]      wa;
  logic signed [31:0] wlo, whi;
  logic [31:0]        wtag;
  logic [AW-1:0]      ra;

  logic signed [31:0] mn_r, mx_r;
  logic signed [32:0] dmin_r, dmax_r;
  logic signed [32:0] d;
  logic               first_r;
  logic [51:0]        prod_r;

  twmr_pkg::out_item_t wk_r;
  twmr_pkg::out_item_t res_nxt;
  twmr_pkg::out_item_t res_r;
  logic                res_v_r;
  logic                out_load;

  // slot arithmetic
  logic [AW-1:0] oldest;
  logic [AW:0]   osum;
  logic [AW-1:0] inc_newest;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  always_comb begin
    osum   = {1'b0, newest_r} + (AW+1)'(DEPTH) + (AW+1)'(1) - (AW+1)'(filled_r);
    if (osum >= (AW+1)'(DEPTH)) osum = osum - (AW+1)'(DEPTH);
    oldest = (DEPTH > 1) ? osum[AW-1:0] : '0;
    inc_newest = (DEPTH > 1) ? wrap_add(newest_r, AW'(1)) : '0;
  end

  assign job_stall = (st_r != S_IDLE);
  assign out_valid = res_v_r;
  assign out_data  = res_r;
  assign d = {hi_q[31], hi_q} - {lo_q[31], lo_q};
  // in S_OUT, the result register loads when empty or being drained this cycle
  assign out_load  = (st_r == S_OUT) && (!res_v_r || !out_stall);

  // memory
  always_ff @(posedge clk) begin
    if (we) begin
      lo_mem[wa]  <= wlo;
      hi_mem[wa]  <= whi;
      tag_mem[wa] <= wtag;
    end
    lo_q  <= lo_mem[ra];
    hi_q  <= hi_mem[ra];
    tag_q <= tag_mem[ra];
  end

  always_comb begin
    ra = ptr_r;
    if (st_r == S_IDLE && job_valid) begin
      ra = (job_data.command == twmr_pkg::CMD_PUSH) ? newest_r :
           (job_data.command == twmr_pkg::CMD_READ) ?
             wrap_add(oldest, AW'(job_data.entry_age)) : oldest;
      if (job_data.command == twmr_pkg::CMD_READ && DEPTH < 32 &&
          {1'b0, job_data.entry_age} >= 6'(DEPTH)) ra = oldest;
    end
  end

  // push write decision in S_CMP
  always_comb begin
    we   = 1'b0;
    wa   = newest_r;
    wlo  = job_r.value_low;
    whi  = job_r.value_high;
    wtag = job_r.tag;
    if (st_r == S_CMP && job_r.command == twmr_pkg::CMD_PUSH) begin
      we = 1'b1;
      if (filled_r == '0) begin
        wa = '0;
      end else if (tag_q == job_r.tag) begin
        wlo = (lo_q > job_r.value_low) ? job_r.value_low : lo_q;
        whi = (hi_q < job_r.value_high) ? job_r.value_high : hi_q;
      end else begin
        wa = inc_newest;
      end
    end
  end

  // final result beat
  always_comb begin
    res_nxt = wk_r;
    if (job_r.command == twmr_pkg::CMD_SUM && wk_r.status == twmr_pkg::StOk) begin
      res_nxt.result_low      = mn_r;
      res_nxt.result_high     = mx_r;
      res_nxt.spread_least    = dmin_r[32] ? 33'd0 : dmin_r;
      res_nxt.spread_greatest = dmax_r[32] ? 33'd0 : dmax_r;
    end
    res_nxt.stored_windows = 6'(filled_r);
  end

  // output register, held while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (out_load) begin
      res_r   <= res_nxt;
      res_v_r <= 1'b1;
    end else if (!out_stall) begin
      res_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      newest_r <= '0;
      filled_r <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (job_valid) begin
            job_r   <= job_data;
            ptr_r   <= ra;
            k_r     <= '0;
            first_r <= 1'b1;
            priority if (job_data.command == twmr_pkg::CMD_CLEAR) begin
              newest_r <= '0;
              filled_r <= '0;
              wk_r     <= '0;
              st_r     <= S_OUT;
            end else if (job_data.command != twmr_pkg::CMD_PUSH && filled_r == '0) begin
              wk_r <= '{status: twmr_pkg::StEmpty, default: '0};
              st_r <= S_OUT;
            end else if (job_data.command == twmr_pkg::CMD_READ &&
                         CW'(job_data.entry_age) >= filled_r && (DEPTH >= 32 ||
                         {1'b0, job_data.entry_age} < 6'(DEPTH))) begin
              wk_r <= '{status: twmr_pkg::StRange, default: '0};
              st_r <= S_OUT;
            end else if (job_data.command == twmr_pkg::CMD_READ && DEPTH < 32 &&
                         {1'b0, job_data.entry_age} >= 6'(DEPTH)) begin
              wk_r <= '{status: twmr_pkg::StRange, default: '0};
              st_r <= S_OUT;
            end else begin
              wk_r <= '0;
              st_r <= S_RD;
            end
          end
        end
        S_RD: begin
          st_r  <= (job_r.command == twmr_pkg::CMD_SUM) ? S_SCAN : S_CMP;
          ptr_r <= wrap_add(ptr_r, AW'(1));
        end
        S_CMP: begin
          if (job_r.command == twmr_pkg::CMD_PUSH) begin
            if (filled_r == '0) begin
              newest_r <= '0;
              filled_r <= CW'(1);
            end else if (tag_q != job_r.tag) begin
              newest_r <= inc_newest;
              if (filled_r < DepthC) filled_r <= filled_r + CW'(1);
            end
            st_r <= S_OUT;
          end else begin
            wk_r   <= '{result_low: lo_q, result_high: hi_q, default: '0};
            prod_r <= tag_q * job_r.period;
            st_r   <= S_MUL;
          end
        end
        S_MUL: begin
          wk_r.window_start <= prod_r[31:0];
          st_r <= S_OUT;
        end
        S_SCAN: begin
          // one window per cycle from oldest
          if (first_r || lo_q < mn_r) mn_r <= lo_q;
          if (first_r || hi_q > mx_r) mx_r <= hi_q;
          if (first_r || d < dmin_r) dmin_r <= d;
          if (first_r || d > dmax_r) dmax_r <= d;
          first_r <= 1'b0;
          ptr_r   <= wrap_add(ptr_r, AW'(1));
          k_r     <= k_r + CW'(1);
          if (k_r + CW'(1) == filled_r) st_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/timed_window_minmax_ring.sv
// Path from input accept to result valid: a push runs the tag divider, then passes
// the queue and the ring update; clear, empty or out-of-range answers, reads and
// summaries pass the queue to the back, and a summary scans every stored window.
// The front holds a push through the divide and takes no new beat until its job
// is handed on; front and back overlap through a two-entry queue. Output stalls hold the back.
// Synchronous active-low reset empties the ring and sets group_r to 60;
// window storage is not cleared.
module timed_window_minmax_ring #(
  parameter int unsigned DEPTH = twmr_pkg::DepthDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [19:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  twmr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output twmr_pkg::out_item_t out_data
);

  logic [19:0]    group_r;
  logic           fj_v, fj_s, bj_v, bj_s;
  twmr_pkg::job_t fj_d, bj_d;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) group_r <= twmr_pkg::GroupReset;
    else if (cfg_we) group_r <= cfg_wdata;
  end

  twmr_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .period(group_r),
    .job_valid(fj_v), .job_stall(fj_s), .job_data(fj_d)
  );

  twmr_queue u_queue (
    .clk, .rst_n, .wr_valid(fj_v), .wr_stall(fj_s), .wr_data(fj_d),
    .rd_valid(bj_v), .rd_stall(bj_s), .rd_data(bj_d)
  );

  twmr_back #(.DEPTH(DEPTH)) u_back (
    .clk, .rst_n, .job_valid(bj_v), .job_stall(bj_s), .job_data(bj_d),
    .out_valid, .out_stall, .out_data
  );

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.stored_windows <= 6'(DEPTH))
    else $error("stored count beyond depth");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == twmr_pkg::StEmpty) |-> out_data.stored_windows == 6'd0)
    else $error("empty status with windows held");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("bad status code");

endmodule
